FILE: rtl/ccb_pkg.sv
package ccb_pkg;

  // largest source image dimension handled by the counters
  localparam int MAX_DIM = 2048;

  localparam int COL_W   = $clog2(MAX_DIM);
  localparam int ROW_W   = COL_W + 1;
  localparam int CFG_W   = 12;
  localparam int CMP_W   = (ROW_W > CFG_W) ? ROW_W : CFG_W;
  localparam int COORD_W = ((CFG_W > COL_W + 1) ? CFG_W : COL_W + 1) + 1;
  localparam int CHAN_W  = 8;
  localparam int ADDR_W  = 22;
  localparam int DATA_W  = 24;
  localparam int IN_TDATA_W  = ((3 * CHAN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_BOTTOM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT     = 3'd7;

  // output pixel formats
  localparam logic [1:0] FMT_XRGB8888 = 2'd0;
  localparam logic [1:0] FMT_RGB565   = 2'd1;

  typedef struct packed {
    logic signed [CFG_W-1:0] dest_x;
    logic signed [CFG_W-1:0] dest_y;
    logic [CFG_W-1:0]        image_width;
    logic [CFG_W-1:0]        image_height;
    logic [CFG_W-1:0]        line_pitch;
    logic [CFG_W-2:0]        section_top;
    logic [CFG_W-1:0]        section_bottom;
    logic [1:0]              out_format;
  } ccb_cfg_t;

  // one accepted write waiting for address and colour conversion
  typedef struct packed {
    logic [CFG_W-1:0]  sx;
    logic [CFG_W-1:0]  sy;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } ccb_item_t;

endpackage

FILE: rtl/ccb_front.sv
module ccb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ccb_pkg::ccb_cfg_t                 cfg,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ccb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output ccb_pkg::ccb_item_t                q_item
);

  logic [ccb_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [ccb_pkg::ROW_W-1:0]          row_r, row_nxt;
  logic [ccb_pkg::COL_W-1:0]          col_cur;
  logic [ccb_pkg::ROW_W-1:0]          row_cur;
  logic [ccb_pkg::CMP_W-1:0]          eff_w;
  logic [ccb_pkg::CMP_W-1:0]          col_inc;
  logic signed [ccb_pkg::COORD_W-1:0] sx;
  logic signed [ccb_pkg::COORD_W-1:0] sy;
  logic [ccb_pkg::CHAN_W-1:0]         red, green, blue;
  logic                               accept;
  logic                               emit;

  assign red   = in_tdata[ccb_pkg::CHAN_W-1:0];
  assign green = in_tdata[2*ccb_pkg::CHAN_W-1:ccb_pkg::CHAN_W];
  assign blue  = in_tdata[3*ccb_pkg::CHAN_W-1:2*ccb_pkg::CHAN_W];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // first pixel restarts the raster at the top-left corner
  assign col_cur = in_tuser ? '0 : col_r;
  assign row_cur = in_tuser ? '0 : row_r;

  assign sx = ccb_pkg::COORD_W'(cfg.dest_x) + ccb_pkg::COORD_W'($signed({1'b0, col_cur}));
  assign sy = ccb_pkg::COORD_W'(cfg.dest_y) + ccb_pkg::COORD_W'($signed({1'b0, row_cur}));

  always_comb begin
    emit = (ccb_pkg::CMP_W'(row_cur) < ccb_pkg::CMP_W'(cfg.image_height))
        && (ccb_pkg::CMP_W'(row_cur) < ccb_pkg::CMP_W'(ccb_pkg::MAX_DIM))
        && !sx[ccb_pkg::COORD_W-1]
        && ($unsigned(sx) < ccb_pkg::COORD_W'(cfg.line_pitch))
        && !sy[ccb_pkg::COORD_W-1]
        && ($unsigned(sy) >= ccb_pkg::COORD_W'(cfg.section_top))
        && ($unsigned(sy) < ccb_pkg::COORD_W'(cfg.section_bottom))
        && ((red | green | blue) != '0)
        && ((cfg.out_format == ccb_pkg::FMT_XRGB8888)
            || (cfg.out_format == ccb_pkg::FMT_RGB565));
  end

  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = ccb_pkg::CMP_W'(1);
    end else if (ccb_pkg::CMP_W'(cfg.image_width) > ccb_pkg::CMP_W'(ccb_pkg::MAX_DIM)) begin
      eff_w = ccb_pkg::CMP_W'(ccb_pkg::MAX_DIM);
    end else begin
      eff_w = ccb_pkg::CMP_W'(cfg.image_width);
    end
  end

  assign col_inc = ccb_pkg::CMP_W'(col_cur) + ccb_pkg::CMP_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        // row saturates at the dimension limit
        if (ccb_pkg::CMP_W'(row_cur) < ccb_pkg::CMP_W'(ccb_pkg::MAX_DIM)) begin
          row_nxt = row_cur + ccb_pkg::ROW_W'(1);
        end else begin
          row_nxt = row_cur;
        end
      end else begin
        col_nxt = col_inc[ccb_pkg::COL_W-1:0];
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign q_push       = accept && emit;
  assign q_item.sx    = sx[ccb_pkg::CFG_W-1:0];
  assign q_item.sy    = sy[ccb_pkg::CFG_W-1:0];
  assign q_item.red   = red;
  assign q_item.green = green;
  assign q_item.blue  = blue;

endmodule

FILE: rtl/ccb_queue.sv
module ccb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ccb_pkg::ccb_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output ccb_pkg::ccb_item_t head_item
);

  ccb_pkg::ccb_item_t         slot_r [ccb_pkg::QUEUE_DEPTH];
  logic [ccb_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [ccb_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [ccb_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == ccb_pkg::QCNT_W'(ccb_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == ccb_pkg::QPTR_W'(ccb_pkg::QUEUE_DEPTH - 1)) ? '0
               : wptr_r + ccb_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == ccb_pkg::QPTR_W'(ccb_pkg::QUEUE_DEPTH - 1)) ? '0
               : rptr_r + ccb_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + ccb_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ccb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/ccb_back.sv
module ccb_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ccb_pkg::ccb_cfg_t               cfg,
  input  logic                            head_valid,
  input  ccb_pkg::ccb_item_t              head_item,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ccb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                                      out_valid_r, out_valid_nxt;
  logic [ccb_pkg::ADDR_W-1:0]                addr_r;
  logic [ccb_pkg::DATA_W-1:0]                data_r;
  logic [ccb_pkg::CFG_W-1:0]                 rel_row;
  logic [2*ccb_pkg::CFG_W-1:0]               prod;
  logic [2*ccb_pkg::CFG_W-1:0]               addr_full;
  logic [ccb_pkg::DATA_W-1:0]                data_c;
  logic [4:0]                                r5, b5;
  logic [5:0]                                g6;

  // floor(x / 255) for x below 256*64: estimate by x/256, at most one correction
  function automatic logic [5:0] div255(input logic [13:0] x);
    logic [5:0] q;
    logic [8:0] rem;
    q   = x[13:8];
    rem = {3'b000, q} + {1'b0, x[7:0]};
    if (rem >= 9'd255) begin
      q = q + 6'd1;
    end
    return q;
  endfunction

  assign r5 = 5'(div255({1'b0, head_item.red, 5'b00000} - {6'b000000, head_item.red}));
  assign b5 = 5'(div255({1'b0, head_item.blue, 5'b00000} - {6'b000000, head_item.blue}));
  assign g6 = div255({head_item.green, 6'b000000} - {6'b000000, head_item.green});

  assign rel_row   = head_item.sy - {1'b0, cfg.section_top};
  assign prod      = rel_row * cfg.line_pitch;
  assign addr_full = prod + (2*ccb_pkg::CFG_W)'(head_item.sx);

  always_comb begin
    if (cfg.out_format == ccb_pkg::FMT_RGB565) begin
      data_c = {8'h00, r5, g6, b5};
    end else begin
      data_c = {head_item.red, head_item.green, head_item.blue};
    end
  end

  assign pop = head_valid && (!out_valid_r || out_tready);

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r <= addr_full[ccb_pkg::ADDR_W-1:0];
      data_r <= data_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ccb_pkg::OUT_TDATA_W'({data_r, addr_r});

endmodule

FILE: rtl/clipped_color_key_blit_unit.sv
// latency: an accepted pixel is registered in the queue and then in the output register
//   that drives out_tvalid; the queue pop waits while that register holds a stalled result
// throughput: one pixel per clock while out_tready is high; set by the combinational
//   front classify and one 12x12 address multiply in the back, two-entry queue between
// dropped pixels (clipped, transparent black, unsupported format) give no output
// reset: synchronous, active low; clears source counters, queue, output valid
//   and loads every configuration register with its reset value
module clipped_color_key_blit_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ccb_pkg::IN_TDATA_W-1:0]  in_tdata,   // red, green, blue
  input  logic                            in_tuser,   // first_pixel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ccb_pkg::OUT_TDATA_W-1:0] out_tdata,  // write_address, write_data, zero pad
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccb_pkg::CFG_W-1:0]       cfg_data
);

  ccb_pkg::ccb_cfg_t  cfg_r;
  ccb_pkg::ccb_item_t push_item;
  ccb_pkg::ccb_item_t head_item;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_x         <= '0;
      cfg_r.dest_y         <= '0;
      cfg_r.image_width    <= ccb_pkg::CFG_W'(1);
      cfg_r.image_height   <= ccb_pkg::CFG_W'(1);
      cfg_r.line_pitch     <= ccb_pkg::CFG_W'(1);
      cfg_r.section_top    <= '0;
      cfg_r.section_bottom <= '0;
      cfg_r.out_format     <= ccb_pkg::FMT_XRGB8888;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccb_pkg::REG_DEST_X:         cfg_r.dest_x         <= $signed(cfg_data);
        ccb_pkg::REG_DEST_Y:         cfg_r.dest_y         <= $signed(cfg_data);
        ccb_pkg::REG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_data;
        ccb_pkg::REG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_data;
        ccb_pkg::REG_LINE_PITCH:     cfg_r.line_pitch     <= cfg_data;
        ccb_pkg::REG_SECTION_TOP:    cfg_r.section_top    <= cfg_data[ccb_pkg::CFG_W-2:0];
        ccb_pkg::REG_SECTION_BOTTOM: cfg_r.section_bottom <= cfg_data;
        ccb_pkg::REG_OUT_FORMAT:     cfg_r.out_format     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  ccb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  ccb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ccb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/ccb_checker.sv
module ccb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ccb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ccb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [ccb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ccb_pkg::CFG_W-1:0]       cfg_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transfer changed");

  // nothing left over from before reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // with the output register empty the queue cannot be full
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // result padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ccb_pkg::OUT_TDATA_W-1:ccb_pkg::ADDR_W+ccb_pkg::DATA_W] == '0)
    else $error("nonzero padding in output transfer");

endmodule

bind clipped_color_key_blit_unit ccb_checker u_ccb_checker (.*);

FILE: bench/clipped_color_key_blit_unit_tb.sv
module clipped_color_key_blit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;

  // formats that give no writes
  localparam logic [1:0] FMT_NO_WRITE_2 = 2'd2;
  localparam logic [1:0] FMT_NO_WRITE_3 = 2'd3;

  typedef struct {
    logic [ccb_pkg::ADDR_W-1:0] addr;
    logic [ccb_pkg::DATA_W-1:0] data;
  } blit_write_t;

  class blit_scoreboard;
    int dest_x, dest_y, image_width, image_height, line_pitch;
    int section_top, section_bottom, out_format;
    int src_col, src_row;
    blit_write_t expected_q[$];
    int errors, pixel_count, write_count;

    function new();
      dest_x = 0;
      dest_y = 0;
      image_width = 1;
      image_height = 1;
      line_pitch = 1;
      section_top = 0;
      section_bottom = 0;
      out_format = 0;
      src_col = 0;
      src_row = 0;
      errors = 0;
      pixel_count = 0;
      write_count = 0;
    endfunction

    function void set_reg(logic [ccb_pkg::CFG_IDX_W-1:0] idx, logic [ccb_pkg::CFG_W-1:0] v);
      case (idx)
        ccb_pkg::REG_DEST_X:         dest_x = $signed(v);
        ccb_pkg::REG_DEST_Y:         dest_y = $signed(v);
        ccb_pkg::REG_IMAGE_WIDTH:    image_width = v;
        ccb_pkg::REG_IMAGE_HEIGHT:   image_height = v;
        ccb_pkg::REG_LINE_PITCH:     line_pitch = v;
        ccb_pkg::REG_SECTION_TOP:    section_top = int'(v[ccb_pkg::CFG_W-2:0]);
        ccb_pkg::REG_SECTION_BOTTOM: section_bottom = v;
        ccb_pkg::REG_OUT_FORMAT:     out_format = int'(v[1:0]);
        default: ;
      endcase
    endfunction

    // place one source pixel, queue the framebuffer write it should give
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic first);
      int sx, sy, w, rr, gg, bb;
      blit_write_t wr;
      rr = r;
      gg = g;
      bb = b;
      pixel_count++;
      if (first) begin
        src_col = 0;
        src_row = 0;
      end
      sx = dest_x + src_col;
      sy = dest_y + src_row;
      if (src_row < image_height && src_row < ccb_pkg::MAX_DIM && sx >= 0 && sx < line_pitch
          && sy >= section_top && sy < section_bottom && (rr | gg | bb) != 0
          && out_format <= 1) begin
        wr.addr = ccb_pkg::ADDR_W'((sy - section_top) * line_pitch + sx);
        if (out_format == ccb_pkg::FMT_XRGB8888) begin
          wr.data = {r, g, b};
        end else begin
          wr.data = ccb_pkg::DATA_W'(((rr * 31 / 255) << 11) | ((gg * 63 / 255) << 5)
                                     | (bb * 31 / 255));
        end
        expected_q.push_back(wr);
      end
      w = (image_width == 0) ? 1
        : (image_width > ccb_pkg::MAX_DIM) ? ccb_pkg::MAX_DIM : image_width;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        if (src_row < ccb_pkg::MAX_DIM) src_row++;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_write(logic [ccb_pkg::ADDR_W-1:0] addr, logic [ccb_pkg::DATA_W-1:0] data);
      blit_write_t exp_w;
      if (expected_q.size() == 0) begin
        report($sformatf("write with none pending, addr %0d data %06h", addr, data));
        return;
      end
      exp_w = expected_q.pop_front();
      write_count++;
      if (addr !== exp_w.addr)
        report($sformatf("write %0d addr %0d, wanted %0d", write_count, addr, exp_w.addr));
      if (data !== exp_w.data)
        report($sformatf("write %0d data %06h, wanted %06h", write_count, data, exp_w.data));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [ccb_pkg::IN_TDATA_W-1:0]  in_tdata;   // red, green, blue
  logic                            in_tuser;   // first_pixel
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ccb_pkg::OUT_TDATA_W-1:0] out_tdata;  // write_address, write_data, zero pad
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ccb_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [ccb_pkg::CFG_W-1:0]       cfg_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int settings_loaded = 0;

  blit_scoreboard sb;

  clipped_color_key_blit_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_write(out_tdata[ccb_pkg::ADDR_W-1:0],
                       out_tdata[ccb_pkg::ADDR_W+ccb_pkg::DATA_W-1:ccb_pkg::ADDR_W]);
      if (in_tvalid && in_tready)
        sb.note_pixel(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tuser);
      if (cfg_valid && cfg_ready)
        sb.set_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {b, g, r};
    in_tuser  <= first;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // idle means every expected write has left and dropped pixels have drained
  task automatic wait_blit_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ccb_pkg::CFG_W-1:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_blit_setting(input ccb_pkg::ccb_cfg_t s);
    wait_blit_idle();
    write_reg(ccb_pkg::REG_DEST_X, s.dest_x);
    write_reg(ccb_pkg::REG_DEST_Y, s.dest_y);
    write_reg(ccb_pkg::REG_IMAGE_WIDTH, s.image_width);
    write_reg(ccb_pkg::REG_IMAGE_HEIGHT, s.image_height);
    write_reg(ccb_pkg::REG_LINE_PITCH, s.line_pitch);
    write_reg(ccb_pkg::REG_SECTION_TOP, {1'b0, s.section_top});
    write_reg(ccb_pkg::REG_SECTION_BOTTOM, s.section_bottom);
    write_reg(ccb_pkg::REG_OUT_FORMAT, {{(ccb_pkg::CFG_W-2){1'b0}}, s.out_format});
    settings_loaded++;
  endtask

  function automatic ccb_pkg::ccb_cfg_t make_setting(int dx, int dy, int iw, int ih, int fbw,
                                                     int top, int bot, logic [1:0] fmt);
    ccb_pkg::ccb_cfg_t s;
    s.dest_x         = 12'(dx);
    s.dest_y         = 12'(dy);
    s.image_width    = 12'(iw);
    s.image_height   = 12'(ih);
    s.line_pitch     = 12'(fbw);
    s.section_top    = 11'(top);
    s.section_bottom = 12'(bot);
    s.out_format     = fmt;
    return s;
  endfunction

  // small geometry most of the time so frames wrap rows and land in the section
  function automatic ccb_pkg::ccb_cfg_t random_setting();
    ccb_pkg::ccb_cfg_t s;
    int top, pick;
    s.dest_x = 12'(int'($urandom_range(0, 15)) - 4);
    case ($urandom_range(0, 19))
      0: s.dest_x = 12'h800;
      1: s.dest_x = 12'h7ff;
      2: s.dest_x = 12'($urandom);
      default: ;
    endcase
    s.dest_y = 12'(int'($urandom_range(0, 8)) - 3);
    case ($urandom_range(0, 19))
      0: s.dest_y = 12'h800;
      1: s.dest_y = 12'h7ff;
      2: s.dest_y = 12'($urandom);
      default: ;
    endcase
    s.image_width = 12'($urandom_range(1, 8));
    if ($urandom_range(0, 29) == 0) s.image_width = '0;
    s.image_height = 12'($urandom_range(1, 6));
    if ($urandom_range(0, 29) == 0) s.image_height = '0;
    s.line_pitch = 12'($urandom_range(1, 16));
    pick = $urandom_range(0, 29);
    if (pick == 0) s.line_pitch = '0;
    else if (pick == 1) s.line_pitch = 12'($urandom);
    top = $urandom_range(0, 6);
    s.section_top = 11'(top);
    if ($urandom_range(0, 19) == 0) s.section_top = 11'($urandom);
    s.section_bottom = 12'(top + int'($urandom_range(0, 9)) - 1);
    pick = $urandom_range(0, 19);
    if (pick < 9) s.out_format = ccb_pkg::FMT_XRGB8888;
    else if (pick < 18) s.out_format = ccb_pkg::FMT_RGB565;
    else if (pick == 18) s.out_format = FMT_NO_WRITE_2;
    else s.out_format = FMT_NO_WRITE_3;
    return s;
  endfunction

  // packed red in the low byte, some black and some zero channels
  function automatic logic [23:0] random_rgb();
    logic [23:0] v;
    v = 24'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      v = '0;
    end else begin
      if ($urandom_range(0, 6) == 0) v[7:0] = '0;
      if ($urandom_range(0, 6) == 0) v[15:8] = '0;
      if ($urandom_range(0, 6) == 0) v[23:16] = '0;
    end
    return v;
  endfunction

  task automatic stream_pixels(input int n, input bit lead_first, input int noise_pct);
    logic [23:0] v;
    logic first;
    for (int i = 0; i < n; i++) begin
      v = random_rgb();
      first = (i == 0 && lead_first) || ($urandom_range(0, 99) < noise_pct);
      push_pixel(v[7:0], v[15:8], v[23:16], first);
    end
  endtask

  initial begin
    ccb_pkg::ccb_cfg_t s;
    int phase_items, n, w;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    send_idle_pct = 28;
    recv_idle_pct = 70;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings after reset: empty section
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);

    load_blit_setting(make_setting(0, 0, 4, 2, 4, 0, 2, ccb_pkg::FMT_XRGB8888));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    push_pixel(8'd128, 8'd64, 8'd32, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd1, 1'b0);
    push_pixel(8'd200, 8'd200, 8'd200, 1'b0);  // row past image height

    load_blit_setting(make_setting(0, 0, 4, 2, 4, 0, 2, ccb_pkg::FMT_RGB565));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    push_pixel(8'd254, 8'd128, 8'd8, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);

    load_blit_setting(make_setting(0, 0, 4, 2, 4, 0, 2, FMT_NO_WRITE_2));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    load_blit_setting(make_setting(0, 0, 4, 2, 4, 0, 2, FMT_NO_WRITE_3));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    // zero image width acts as one pixel per row
    load_blit_setting(make_setting(0, 0, 0, 3, 2, 1, 3, ccb_pkg::FMT_XRGB8888));
    push_pixel(8'd9, 8'd9, 8'd9, 1'b1);
    push_pixel(8'd8, 8'd8, 8'd8, 1'b0);
    push_pixel(8'd7, 8'd7, 8'd7, 1'b0);

    load_blit_setting(make_setting(0, 0, 4, 2, 0, 0, 2, ccb_pkg::FMT_RGB565));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    // address wraps past 22 bits
    load_blit_setting(make_setting(2047, 2047, 1, 2, 4095, 0, 4095, ccb_pkg::FMT_XRGB8888));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd17, 8'd34, 8'd51, 1'b0);

    load_blit_setting(make_setting(-2048, -2048, 4, 4, 16, 0, 16, ccb_pkg::FMT_RGB565));
    push_pixel(8'd255, 8'd1, 8'd1, 1'b1);

    // image wider than the counter limit
    load_blit_setting(make_setting(0, 0, 4095, 2, 16, 0, 2, ccb_pkg::FMT_RGB565));
    stream_pixels(20, 1'b1, 0);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 28; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_items = 0;
      while (phase_items < 120) begin
        s = random_setting();
        load_blit_setting(s);
        w = (s.image_width == 0) ? 1 : int'(s.image_width);
        n = w * (int'(s.image_height) + 1) + int'($urandom_range(0, 3));
        if (n > 60) n = 60;
        stream_pixels(n, $urandom_range(0, 9) != 0, ($urandom_range(0, 4) == 0) ? 8 : 0);
        phase_items += n;
      end
    end

    wait_blit_idle();
    $display("run covered %0d pixels, %0d framebuffer writes checked, %0d register settings",
             sb.pixel_count, sb.write_count, settings_loaded);
    $display("clipping, colour key, both formats, dropped formats, odd widths and stalls");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
